>>> rtl/core/first_fit_block_allocator_assert.svh
// assertion macros for the first-fit block allocator
// depends on signals named clk and rst_n in the including module
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, masked during reset
`define FFBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffba: same-cycle check failed");

// next-cycle implication, masked during reset
`define FFBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffba: next-cycle check failed");

`endif

>>> rtl/core/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies
package ffba_pkg;

  localparam int ARENA_BYTES  = 1024;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 16;

  localparam int REQ_W  = 12;
  localparam int OFS_W  = 10;
  localparam int SIZE_W = 10;
  localparam int ST_W   = 2;
  // header walk position, arena plus one header
  localparam int ACC_W  = 12;
  // padded request and split threshold
  localparam int WANT_W = 13;

  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - HEADER_BYTES);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic advance;
    logic take;
    logic miss;
    logic shift_step;
    logic split_wr;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic at_end;
    logic hit;
    logic split;
    logic no_shift;
    logic shift_last;
  } sts_t;

endpackage

>>> rtl/core/ffba_ram.sv
// generic one-write one-read ram with registered read data
// no dependencies
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ffba_ctrl.sv
// control state machine of the first-fit block allocator
// depends on ffba_pkg
module ffba_ctrl
  import ffba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SPLIT = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.at_end) begin
          cmd.miss  = 1'b1;
          state_nxt = S_RESP;
        end else if (sts.hit) begin
          cmd.take = 1'b1;
          if (!sts.split) begin
            state_nxt = S_RESP;
          end else if (sts.no_shift) begin
            state_nxt = S_SPLIT;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (sts.shift_last) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split_wr = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/ffba_dp.sv
// datapath of the first-fit block allocator: block table, walk and result registers
// depends on ffba_pkg and ffba_ram
module ffba_dp
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_mode,
  input  logic [REQ_W-1:0]  in_request_size,
  input  logic [OFS_W-1:0]  in_free_offset,
  output logic [ST_W-1:0]   out_status,
  output logic [OFS_W-1:0]  out_data_offset,
  output logic [SIZE_W-1:0] out_granted_size
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic              mode_r;
  logic [WANT_W-1:0] want_r;
  logic [OFS_W-1:0]  off_r;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     sh_r, sh_nxt;
  logic [ACC_W-1:0]  hdr_r, hdr_nxt;
  logic [SIZE_W-1:0] sz_r;
  logic              rd_is0_r;
  logic              e0_wr_r, e0_wr_nxt;
  logic [ST_W-1:0]   res_status_r;
  logic [OFS_W-1:0]  res_ofs_r;
  logic [SIZE_W-1:0] res_size_r;
  logic [ST_W-1:0]   out_status_r;
  logic [OFS_W-1:0]  out_ofs_r;
  logic [SIZE_W-1:0] out_size_r;

  logic [WANT_W-1:0] want_in;
  logic [WANT_W-1:0] need;
  logic [ACC_W-1:0]  start_ofs;
  entry_t            rdata, ent, take_ent;
  logic [IW-1:0]     raddr, waddr;
  entry_t            wdata;
  logic              we;
  logic [CW:0]       idx_p1, idx_p2;

  // round the request up to the alignment
  assign want_in = (WANT_W'(in_request_size) + WANT_W'(ALIGN_BYTES - 1))
                   & ~WANT_W'(ALIGN_BYTES - 1);
  assign need      = want_r + WANT_W'(HEADER_BYTES + ALIGN_BYTES);
  assign start_ofs = hdr_r + ACC_W'(HEADER_BYTES);
  assign idx_p1    = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2    = {1'b0, idx_r} + (CW+1)'(2);

  // first block holds the whole arena until it is first written
  assign ent = (rd_is0_r && !e0_wr_r) ? entry_t'{used: 1'b0, size: INIT_SIZE} : rdata;

  always_comb begin
    sts.at_end     = (idx_r == cnt_r);
    sts.split      = (mode_r == MODE_ALLOC) && (WANT_W'(ent.size) >= need)
                     && (cnt_r < CW'(MAX_BLOCKS));
    sts.no_shift   = (idx_p1 == {1'b0, cnt_r});
    sts.shift_last = ({1'b0, sh_r} == idx_p2);
    if (mode_r == MODE_FREE) begin
      sts.hit = (start_ofs == ACC_W'(off_r));
    end else begin
      sts.hit = !ent.used && (WANT_W'(ent.size) >= want_r);
    end
  end

  always_comb begin
    take_ent.used = (mode_r == MODE_ALLOC);
    take_ent.size = sts.split ? SIZE_W'(want_r) : ent.size;
  end

  // ram port control
  always_comb begin
    raddr = idx_p1[IW-1:0];
    we    = 1'b0;
    waddr = idx_r[IW-1:0];
    wdata = take_ent;
    if (cmd.start) begin
      raddr = '0;
    end else if (cmd.take) begin
      raddr = IW'(cnt_r - CW'(1));
      we    = 1'b1;
    end else if (cmd.shift_step) begin
      raddr = IW'(sh_r - CW'(2));
      we    = 1'b1;
      waddr = sh_r[IW-1:0];
      wdata = ent;
    end else if (cmd.split_wr) begin
      we         = 1'b1;
      waddr      = idx_p1[IW-1:0];
      wdata.used = 1'b0;
      wdata.size = sz_r - SIZE_W'(want_r) - SIZE_W'(HEADER_BYTES);
    end
  end

  ffba_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    idx_nxt   = idx_r;
    hdr_nxt   = hdr_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    e0_wr_nxt = e0_wr_r | (we && (waddr == '0));
    if (cmd.start) begin
      idx_nxt = '0;
      hdr_nxt = '0;
    end
    if (cmd.advance) begin
      idx_nxt = idx_p1[CW-1:0];
      hdr_nxt = start_ofs + ACC_W'(ent.size);
    end
    if (cmd.take) begin
      sh_nxt = cnt_r;
    end
    if (cmd.shift_step) begin
      sh_nxt = sh_r - CW'(1);
    end
    if (cmd.split_wr) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= CW'(1);
      e0_wr_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      e0_wr_r <= e0_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    hdr_r    <= hdr_nxt;
    sh_r     <= sh_nxt;
    rd_is0_r <= (raddr == '0);
    if (cmd.start) begin
      mode_r <= in_mode;
      want_r <= want_in;
      off_r  <= in_free_offset;
    end
    if (cmd.take) begin
      sz_r         <= ent.size;
      res_status_r <= ST_OK;
      res_ofs_r    <= start_ofs[OFS_W-1:0];
      res_size_r   <= take_ent.size;
    end
    if (cmd.miss) begin
      res_status_r <= (mode_r == MODE_FREE) ? ST_BADFREE : ST_NOFIT;
      res_ofs_r    <= '0;
      res_size_r   <= '0;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_ofs_r    <= res_ofs_r;
      out_size_r   <= res_size_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_data_offset  = out_ofs_r;
  assign out_granted_size = out_size_r;

endmodule

>>> rtl/core/first_fit_block_allocator.sv
// top level of the first-fit block allocator over a 1024-byte arena
// depends on ffba_pkg, ffba_ctrl, ffba_dp, ffba_ram and first_fit_block_allocator_assert.svh
//
//   channel | ports                                              | direction
//   --------+----------------------------------------------------+----------
//   input   | in_valid, in_stall, in_mode, in_request_size,      | in
//           | in_free_offset                                     |
//   result  | out_valid, out_stall, out_status, out_data_offset, | out
//           | out_granted_size                                   |
//
// one item at a time: accept, then walk the table entry by entry (a miss walks
// one past the last), for a split at entry i shift entries i+1 to the end up by
// one, write the split-off free block, then load the result register
// reset (synchronous, active low) leaves one free block of 1008 data bytes
// the next item is taken while an earlier result still waits under out_stall
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_mode,
  input  logic [REQ_W-1:0]  in_request_size,
  input  logic [OFS_W-1:0]  in_free_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [OFS_W-1:0]  out_data_offset,
  output logic [SIZE_W-1:0] out_granted_size
);

  // command and status between controller and datapath
  cmd_t ctrl_cmd;
  sts_t dp_sts;

  // sequencer: accept, walk, shift, split write, hand off to the result register
  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (dp_sts),
    .cmd      (ctrl_cmd)
  );

  // block table ram, header walk and result registers
  ffba_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctrl_cmd),
    .sts             (dp_sts),
    .in_mode         (in_mode),
    .in_request_size (in_request_size),
    .in_free_offset  (in_free_offset),
    .out_status      (out_status),
    .out_data_offset (out_data_offset),
    .out_granted_size(out_granted_size)
  );

  `include "first_fit_block_allocator_assert.svh"

  // a result is only loaded when the output register is free or draining
  `FFBA_ASSERT_IMP(a_load_free, ctrl_cmd.load_out, !out_valid || !out_stall)
  // one item in flight: an accepted transaction closes the input side
  `FFBA_ASSERT_NXT(a_one_item, in_valid && !in_stall, in_stall)
  // a delivered result without a reload empties the output register
  `FFBA_ASSERT_NXT(a_out_drain, out_valid && !out_stall && !ctrl_cmd.load_out, !out_valid)
  // error results carry zero offset and size
  `FFBA_ASSERT_IMP(a_err_zero, out_valid && (out_status != ST_OK),
                   (out_data_offset == '0) && (out_granted_size == '0))

endmodule
